FILE: hw/rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the row statistics labeler
// Item structs, the front-to-back operation record, codes and defaults.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int MAX_FEATURES_DEF = 32;
    localparam int CLASS_SLOTS_DEF  = 64;

    // fixed widths of the operation record (cover the full parameter range)
    localparam int POS_W  = 9;
    localparam int FIDX_W = 8;
    localparam int COL_W  = 6;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_MIXED = 3'd1;
    localparam logic [2:0] ERR_CLASS = 3'd2;
    localparam logic [2:0] ERR_FULL  = 3'd3;
    localparam logic [2:0] ERR_WIDE  = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [63:0] field_value;
        logic        last_in_row;
        logic [4:0]  feature_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  class_label;
        logic [2:0]  status;
        logic [63:0] min_value;
        logic [63:0] max_value;
        logic [31:0] rows_seen;
        logic [5:0]  features_per_row;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_READ,
        OP_READ_NONE,
        OP_CLASS,
        OP_FEAT,
        OP_WIDE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [63:0]        value;
        logic               last;
        logic [FIDX_W-1:0]  fidx;
        logic [POS_W-1:0]   count;
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_FOLD,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/drs_queue.sv
// ----------------------------------------------------------------------------
// drs_queue: two-entry operation queue
// Decouples the classifying front from the executing back.
// ----------------------------------------------------------------------------
module drs_queue
    import drs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_data,
    output logic o_empty
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/drs_front.sv
// ----------------------------------------------------------------------------
// drs_front: input acceptance and field classification
// Tracks the column position and maps each item to an operation record.
// ----------------------------------------------------------------------------
module drs_front
    import drs_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_in_item         i_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [COL_W-1:0] i_cfg_data,
    output logic [COL_W-1:0] o_class_col,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_op              o_q_data
);

    logic [COL_W-1:0] r_class_col;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] col_ext;
    logic [POS_W-1:0] feat;
    logic [POS_W-1:0] cnt;

    assign o_cfg_ready = 1'b1;
    assign o_class_col = r_class_col;
    assign o_q_push    = i_push && !i_q_full;

    always_comb begin
        col_ext = POS_W'(r_class_col);
        feat    = r_pos - ((r_pos > col_ext) ? POS_W'(1) : POS_W'(0));
        // saturate: after an error the position no longer matters
        cnt     = (&r_pos) ? r_pos : r_pos + POS_W'(1);

        o_q_data.value = i_item.field_value;
        o_q_data.last  = i_item.last_in_row;
        o_q_data.count = cnt;
        o_q_data.fidx  = FIDX_W'(feat);
        o_q_data.kind  = OP_FEAT;
        n_pos          = r_pos;

        if (i_item.req_type) begin
            o_q_data.fidx = FIDX_W'(i_item.feature_index);
            o_q_data.kind = (32'(i_item.feature_index) >= MAX_FEATURES) ?
                            OP_READ_NONE : OP_READ;
        end else begin
            if (r_pos == col_ext) begin
                o_q_data.kind = OP_CLASS;
            end else if (32'(feat) >= MAX_FEATURES) begin
                o_q_data.kind = OP_WIDE;
            end
            n_pos = i_item.last_in_row ? '0 : cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_col <= '0;
            r_pos       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_class_col <= i_cfg_data;
            end
            if (o_q_push) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

FILE: hw/rtl/drs_back.sv
// ----------------------------------------------------------------------------
// drs_back: operation execution
// Class table search, min/max folding, row checks and the result register.
// ----------------------------------------------------------------------------
module drs_back
    import drs_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int CLASS_SLOTS  = CLASS_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_class_col,
    input  logic             i_q_empty,
    input  t_op              i_q_data,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output t_out_item        o_item
);

    localparam int FA  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CAW = $clog2(CLASS_SLOTS);
    localparam int CW  = $clog2(CLASS_SLOTS + 1);

    function automatic logic is_nan(input logic [63:0] a);
        return (&a[62:52]) && (|a[51:0]);
    endfunction

    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (a[62:0] == '0 && b[62:0] == '0) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = a[63];
        end else if (!a[63]) begin
            res = a[62:0] < b[62:0];
        end else begin
            res = a[62:0] > b[62:0];
        end
        return res;
    endfunction

    function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
        return !is_nan(a) && !is_nan(b) &&
               ((a == b) || (a[62:0] == '0 && b[62:0] == '0));
    endfunction

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [2:0]       r_err, n_err;
    logic [2:0]       r_sticky, n_sticky;
    logic [CW-1:0]    r_pending, n_pending;
    logic [CW-1:0]    r_entries, n_entries;
    logic [CAW-1:0]   r_idx, n_idx;
    logic [POS_W-1:0] r_row_width, n_row_width;
    logic [31:0]      r_rows, n_rows;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             cls_wr_en;
    logic [CAW-1:0]   cls_rd_addr;
    logic [63:0]      cls_rd_data;
    logic             min_wr_en, max_wr_en;
    logic [FA-1:0]    feat_wr_addr, feat_rd_addr;
    logic [63:0]      feat_wr_data, min_rd_data, max_rd_data;

    logic             out_free;
    logic             hit, at_end;
    logic [POS_W-1:0] n1;
    logic [2:0]       err_c;

    drs_ram #(.WIDTH(64), .DEPTH(CLASS_SLOTS)) u_class_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cls_wr_en),
        .i_wr_addr (r_entries[CAW-1:0]),
        .i_wr_data (r_op.value),
        .i_rd_addr (cls_rd_addr),
        .o_rd_data (cls_rd_data)
    );

    drs_ram #(.WIDTH(64), .DEPTH(MAX_FEATURES)) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (min_wr_en),
        .i_wr_addr (feat_wr_addr),
        .i_wr_data (feat_wr_data),
        .i_rd_addr (feat_rd_addr),
        .o_rd_data (min_rd_data)
    );

    drs_ram #(.WIDTH(64), .DEPTH(MAX_FEATURES)) u_max_ram (
        .i_clk     (i_clk),
        .i_wr_en   (max_wr_en),
        .i_wr_addr (feat_wr_addr),
        .i_wr_data (feat_wr_data),
        .i_rd_addr (feat_rd_addr),
        .o_rd_data (max_rd_data)
    );

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_err       = r_err;
        n_sticky    = r_sticky;
        n_pending   = r_pending;
        n_entries   = r_entries;
        n_idx       = r_idx;
        n_row_width = r_row_width;
        n_rows      = r_rows;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        out_free    = !r_out_valid || i_pop;

        o_q_pop      = 1'b0;
        cls_wr_en    = 1'b0;
        cls_rd_addr  = '0;
        min_wr_en    = 1'b0;
        max_wr_en    = 1'b0;
        feat_wr_addr = r_op.fidx[FA-1:0];
        feat_wr_data = r_op.value;
        feat_rd_addr = r_op.fidx[FA-1:0];

        hit    = (r_entries != '0) && f_eq(cls_rd_data, r_op.value);
        at_end = (r_entries == '0) || (CW'(r_idx) + CW'(1) == r_entries);
        n1     = r_op.count - POS_W'(1);
        err_c  = r_err;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_data;
                    n_err   = ERR_NONE;
                    case (i_q_data.kind) inside
                        OP_READ, OP_READ_NONE: begin
                            feat_rd_addr = i_q_data.fidx[FA-1:0];
                            n_state      = S_READ;
                        end
                        default: begin
                            if (r_sticky != ERR_NONE) begin
                                // frozen: only a row end reports
                                if (i_q_data.last) begin
                                    n_err   = r_sticky;
                                    n_state = S_DONE;
                                end
                            end else if (i_q_data.kind == OP_CLASS) begin
                                n_idx   = '0;
                                n_state = S_SEARCH;
                            end else if (i_q_data.kind == OP_FEAT) begin
                                feat_rd_addr = i_q_data.fidx[FA-1:0];
                                if (r_rows == '0) begin
                                    // first row seeds both bounds
                                    feat_wr_addr = i_q_data.fidx[FA-1:0];
                                    feat_wr_data = i_q_data.value;
                                    min_wr_en    = 1'b1;
                                    max_wr_en    = 1'b1;
                                    n_state      = S_DONE;
                                end else begin
                                    n_state = S_FOLD;
                                end
                            end else begin
                                n_err   = ERR_WIDE;
                                n_state = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.class_label      = '0;
                    n_out.status           = r_sticky;
                    n_out.min_value        = (r_op.kind == OP_READ) ? min_rd_data : '0;
                    n_out.max_value        = (r_op.kind == OP_READ) ? max_rd_data : '0;
                    n_out.rows_seen        = r_rows;
                    n_out.features_per_row = 6'(r_row_width);
                    n_state                = S_IDLE;
                end
            end
            S_SEARCH: begin
                cls_rd_addr = r_idx + CAW'(1);
                if (hit) begin
                    n_pending = CW'(r_idx) + CW'(1);
                    n_state   = S_DONE;
                end else if (at_end) begin
                    if (32'(r_entries) >= CLASS_SLOTS) begin
                        n_err = ERR_FULL;
                    end else begin
                        cls_wr_en = 1'b1;
                        n_entries = r_entries + CW'(1);
                        n_pending = r_entries + CW'(1);
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + CAW'(1);
                end
            end
            S_FOLD: begin
                if (f_lt(r_op.value, min_rd_data)) begin
                    min_wr_en = 1'b1;
                end else if (f_lt(max_rd_data, r_op.value)) begin
                    max_wr_en = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_err == ERR_NONE && r_op.last) begin
                    if (r_row_width == '0) begin
                        n_row_width = n1;
                        if (POS_W'(i_class_col) > n1) begin
                            err_c = ERR_CLASS;
                        end
                    end
                    if (err_c == ERR_NONE && n_row_width != n1) begin
                        err_c = ERR_MIXED;
                    end
                end
                if (!r_op.last) begin
                    if (err_c != ERR_NONE) begin
                        n_sticky  = err_c;
                        n_pending = '0;
                    end
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.min_value = '0;
                    n_out.max_value = '0;
                    n_out.status    = err_c;
                    n_pending       = '0;
                    if (err_c != ERR_NONE) begin
                        n_sticky          = err_c;
                        n_out.class_label = '0;
                    end else begin
                        n_rows            = (&r_rows) ? r_rows : r_rows + 32'd1;
                        n_out.class_label = 7'(r_pending);
                    end
                    n_out.rows_seen        = n_rows;
                    n_out.features_per_row = 6'(n_row_width);
                    n_state                = S_IDLE;
                end else begin
                    // hold until the result register frees up
                    n_row_width = r_row_width;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= ERR_NONE;
            r_sticky    <= ERR_NONE;
            r_pending   <= '0;
            r_entries   <= '0;
            r_idx       <= '0;
            r_row_width <= '0;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_sticky    <= n_sticky;
            r_pending   <= n_pending;
            r_entries   <= n_entries;
            r_idx       <= n_idx;
            r_row_width <= n_row_width;
            r_rows      <= n_rows;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_out <= n_out;
    end

endmodule

FILE: hw/rtl/dataset_row_stats_labeler.sv
// ----------------------------------------------------------------------------
// dataset_row_stats_labeler: row field statistics and class labeling
// Per-feature running min/max of double fields plus class value labels.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive i_in_item and raise push; a transfer happens on a
//   clock edge with push high and full low. req_type 0 carries one row field
//   (last_in_row marks the row end), req_type 1 asks for one feature's stats.
//   Result queue side: while empty is low o_out_item holds the oldest result;
//   pop high on a clock edge transfers it. A row end and a read give one
//   result each, other fields give none.
//   Config: i_cfg_valid/o_cfg_ready write class_column; write only when idle.
// Stages: a front stage classifies each field, a two-entry queue feeds the
//   back stage, which pops one operation only when idle. A read passes
//   through S_READ, a feature fold through S_FOLD and S_DONE, a first-row
//   feature or too-wide field straight to S_DONE, and a class field through
//   S_SEARCH, one class table entry at a time (at least one; the table RAM
//   has one read port), then S_DONE.
// Reset: synchronous, active low; clears counts, row width, the class table
//   fill count and the error. Stored min/max values are not cleared.
// Stall: with the result register full the back stage waits; the queue keeps
//   taking up to two items before full rises.
// ----------------------------------------------------------------------------
module dataset_row_stats_labeler
    import drs_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int CLASS_SLOTS  = CLASS_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_in_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [COL_W-1:0] i_cfg_data
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_op              q_in;
    t_op              q_out;
    logic [COL_W-1:0] class_col;

    assign full = q_full;

    // front: column tracking and classification
    drs_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_class_col (class_col),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    // operation queue between the stages
    drs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // back: table search, folding, row checks, result register
    drs_back #(
        .MAX_FEATURES (MAX_FEATURES),
        .CLASS_SLOTS  (CLASS_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_class_col (class_col),
        .i_q_empty   (q_empty),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

FILE: test/dataset_row_stats_labeler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dataset_row_stats_labeler_test: self-checking bench for the row labeler
// Streams rows of double fields and feature reads through the input queue.
// A local copy of the labeler state predicts every result, and the results
// are compared in order. Random bursts, gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module dataset_row_stats_labeler_test;
    import drs_pkg::*;

    localparam int N_FEAT  = MAX_FEATURES_DEF;
    localparam int N_SLOTS = CLASS_SLOTS_DEF;
    localparam int SETTLE  = 120;     // > worst class search plus pipeline

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    t_in_item         i_in_item;
    logic             empty;
    logic             pop;
    t_out_item        o_out_item;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [COL_W-1:0] i_cfg_data;

    dataset_row_stats_labeler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("dataset_row_stats_labeler verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the labeler state
    // ------------------------------------------------------------------------
    int          shadow_class_col;
    int          shadow_col_pos;
    int          shadow_width;
    logic [31:0] shadow_rows;
    logic [63:0] shadow_classes [N_SLOTS];
    int          shadow_entries;
    logic [63:0] shadow_min [N_FEAT];
    logic [63:0] shadow_max [N_FEAT];
    int          shadow_label;
    logic [2:0]  shadow_err;

    t_in_item  pending_items [$];   // items waiting for the driver
    t_out_item expected_results [$];
    int        fail_count = 0;

    function automatic t_out_item make_result(int label, logic [2:0] st,
                                              logic [63:0] mn, logic [63:0] mx);
        t_out_item r;
        r.class_label      = label[6:0];
        r.status           = st;
        r.min_value        = mn;
        r.max_value        = mx;
        r.rows_seen        = shadow_rows;
        r.features_per_row = shadow_width[5:0];
        return r;
    endfunction

    // Applies one accepted transfer to the shadow state.
    task automatic apply_transfer(t_in_item it);
        logic [2:0] err;
        int         f;
        int         lab;
        real        x;
        err = ERR_NONE;
        if (it.req_type) begin
            expected_results.push_back(make_result(0, shadow_err,
                shadow_min[it.feature_index], shadow_max[it.feature_index]));
            return;
        end
        if (shadow_err != ERR_NONE) begin
            if (it.last_in_row)
                expected_results.push_back(make_result(0, shadow_err, 64'd0, 64'd0));
            return;
        end
        x = $bitstoreal(it.field_value);
        if (shadow_col_pos == shadow_class_col) begin
            // value compare: zeros match each other, NaN matches nothing
            lab = 0;
            for (int i = 0; i < shadow_entries; i++)
                if (lab == 0 && $bitstoreal(shadow_classes[i]) == x) lab = i + 1;
            if (lab == 0 && shadow_entries < N_SLOTS) begin
                shadow_classes[shadow_entries] = it.field_value;
                shadow_entries++;
                lab = shadow_entries;
            end
            if (lab == 0) err = ERR_FULL;
            else          shadow_label = lab;
        end else begin
            f = shadow_col_pos - ((shadow_col_pos > shadow_class_col) ? 1 : 0);
            if (f >= N_FEAT) begin
                err = ERR_WIDE;
            end else if (shadow_rows == 0) begin
                shadow_min[f] = it.field_value;
                shadow_max[f] = it.field_value;
            end else if (x < $bitstoreal(shadow_min[f])) begin
                shadow_min[f] = it.field_value;
            end else if (x > $bitstoreal(shadow_max[f])) begin
                shadow_max[f] = it.field_value;
            end
        end
        if (err == ERR_NONE) begin
            shadow_col_pos++;
            if (!it.last_in_row) return;
            if (shadow_width == 0) begin
                shadow_width = shadow_col_pos - 1;
                if (shadow_class_col > shadow_col_pos - 1) err = ERR_CLASS;
            end
            if (err == ERR_NONE && shadow_width != shadow_col_pos - 1) err = ERR_MIXED;
        end
        if (err != ERR_NONE) begin
            shadow_err     = err;
            shadow_col_pos = 0;
            shadow_label   = 0;
            if (it.last_in_row)
                expected_results.push_back(make_result(0, err, 64'd0, 64'd0));
            return;
        end
        if (shadow_rows != 32'hFFFF_FFFF) shadow_rows++;
        expected_results.push_back(make_result(shadow_label, ERR_NONE, 64'd0, 64'd0));
        shadow_col_pos = 0;
        shadow_label   = 0;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n) begin
            push       <= 1'b0;
            i_in_item  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (push && !full) begin
                apply_transfer(i_in_item);
                void'(pending_items.pop_front());
            end
            nxt = 1'b0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                nxt = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    // about a third of bursts run back to back
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            push <= nxt;
            if (nxt) i_in_item <= pending_items[0];
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares results in order; stalls on its own pattern
    // ------------------------------------------------------------------------
    int pop_mode_left;
    int pop_mode;
    int hold_left;
    int results_seen;
    bit hold_done;

    always @(posedge i_clk) begin
        t_out_item want;
        logic      nxt;
        if (!i_rst_n) begin
            pop           <= 1'b0;
            pop_mode_left <= 0;
            pop_mode      <= 0;
            hold_left     <= 0;
            results_seen  <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result, label %0d status %0d",
                           o_out_item.class_label, o_out_item.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.class_label !== want.class_label) begin
                        $error("class_label exp %0d got %0d", want.class_label,
                               o_out_item.class_label);
                        fail_count++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, o_out_item.status);
                        fail_count++;
                    end
                    if (o_out_item.min_value !== want.min_value) begin
                        $error("min_value exp %h got %h", want.min_value,
                               o_out_item.min_value);
                        fail_count++;
                    end
                    if (o_out_item.max_value !== want.max_value) begin
                        $error("max_value exp %h got %h", want.max_value,
                               o_out_item.max_value);
                        fail_count++;
                    end
                    if (o_out_item.rows_seen !== want.rows_seen) begin
                        $error("rows_seen exp %0d got %0d", want.rows_seen,
                               o_out_item.rows_seen);
                        fail_count++;
                    end
                    if (o_out_item.features_per_row !== want.features_per_row) begin
                        $error("features_per_row exp %0d got %0d",
                               want.features_per_row, o_out_item.features_per_row);
                        fail_count++;
                    end
                end
            end
            // one long hold-off so the block backs up and raises full
            if (!hold_done && results_seen == 150) begin
                hold_done <= 1'b1;
                hold_left <= 600;
            end
            if (pop_mode_left == 0) begin
                pop_mode_left <= $urandom_range(16, 96);
                pop_mode      <= $urandom_range(0, 2);
            end else begin
                pop_mode_left <= pop_mode_left - 1;
            end
            case (pop_mode)
                0:       nxt = 1'b1;
                1:       nxt = ($urandom_range(0, 3) != 0);
                default: nxt = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                nxt = 1'b0;
            end
            pop <= nxt;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int          row_feats;      // features per row fixed by the first row
    int          readable;       // features written so far (safe to read)
    int          gen_class_col;
    logic [63:0] class_pool [$];

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 64'h0000_0000_0000_0000;
            1:       return 64'h8000_0000_0000_0000;
            2:       return {12'hFFF, 1'b1, 51'($urandom)} ^ 64'(($urandom & 1) << 63);
            3:       return 64'h7FF0_0000_0000_0000;
            4:       return 64'hFFF0_0000_0000_0000;
            5:       return 64'hFFFF_FFFF_FFFF_FFFF;
            6:       return 64'h7FEF_FFFF_FFFF_FFFF;
            7, 8:    return $realtobits(real'(int'($urandom_range(0, 40)) - 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_class();
        logic [63:0] v;
        int          r;
        r = $urandom_range(0, 15);
        if (r < 11 && class_pool.size() > 0)
            return class_pool[$urandom_range(0, class_pool.size() - 1)];
        if (r == 11) return 64'h8000_0000_0000_0000;   // minus zero meets plus zero
        if (r == 12) return 64'h7FF8_0000_0000_0001;   // NaN, always a new entry
        v = (r == 13) ? 64'h0 : {$urandom, $urandom};
        if (class_pool.size() < 8) class_pool.push_back(v);
        return v;
    endfunction

    task automatic add_item(logic rt, logic [63:0] v, logic lst, logic [4:0] fi);
        t_in_item it;
        it.req_type      = rt;
        it.field_value   = v;
        it.last_in_row   = lst;
        it.feature_index = fi;
        pending_items.push_back(it);
    endtask

    task automatic add_read();
        if (readable > 0)
            add_item(1'b1, {$urandom, $urandom}, 1'($urandom), 5'($urandom_range(0, readable - 1)));
    endtask

    // one row of n fields, class value at the configured column
    task automatic add_row(int n, logic [63:0] cls);
        for (int c = 0; c < n; c++) begin
            if ($urandom_range(0, 5) == 0) add_read();
            add_item(1'b0, (c == gen_class_col) ? cls : pick_value(),
                     c == n - 1, 5'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_class_col(int col);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= COL_W'(col);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid      <= 1'b0;
        shadow_class_col = col;
        gen_class_col    = col;
    endtask

    initial begin
        int ending;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        shadow_class_col = 0;
        shadow_col_pos   = 0;
        shadow_width     = 0;
        shadow_rows      = 0;
        shadow_entries   = 0;
        shadow_label     = 0;
        shadow_err       = ERR_NONE;
        foreach (shadow_min[i]) begin
            shadow_min[i] = '0;
            shadow_max[i] = '0;
        end
        gen_class_col = 0;
        readable      = 0;
        ending        = $urandom_range(0, 7);
        // the table-fill ending keeps rows short to hold the item count down
        row_feats     = (ending % 3 == 2) ? $urandom_range(1, 6) :
                        (($urandom_range(0, 1) == 0) ? N_FEAT : $urandom_range(1, N_FEAT));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_class_col(0);

        if (ending == 0) begin
            // class column past the end of the first real row
            write_class_col(5);
            add_row(3, 64'h0);
            readable = 3;
            repeat (1600) begin
                if ($urandom_range(0, 1) == 0) add_read();
                else add_item(1'b0, pick_value(), ($urandom_range(0, 3) == 0), 5'($urandom));
            end
        end else begin
            // first real row fixes the width; class at column 0
            add_row(row_feats + 1, 64'h8000_0000_0000_0000);
            readable = row_feats;
            // directed rows: extremes of the doubles and matching zeros
            add_row(row_feats + 1, 64'h0);
            add_row(row_feats + 1, 64'h7FF8_0000_0000_0000);
            add_row(row_feats + 1, 64'h7FF8_0000_0000_0000);
            add_item(1'b1, 64'h0, 1'b0, 5'd0);
            add_item(1'b1, '1, 1'b1, 5'(readable - 1));
            wait_idle();

            for (int ph = 0; ph < 6; ph++) begin
                write_class_col(ph == 0 ? row_feats : ph == 1 ? 0
                                : $urandom_range(0, row_feats));
                for (int k = 0; k < 220; ) begin
                    add_row(row_feats + 1, pick_class());
                    k += row_feats + 1;
                end
                wait_idle();
            end

            case (ending % 3)
                0: add_row(row_feats, pick_class());                  // mixed width
                1: add_row(N_FEAT + 3, pick_class());                 // too wide
                default: repeat (N_SLOTS + 2) add_row(row_feats + 1, {$urandom, $urandom});
            endcase
            // sticky error: pushes only report it, reads keep working
            repeat (4) add_row(row_feats + 1, pick_class());
            repeat (20) add_read();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("dataset_row_stats_labeler verification clean");
        end else begin
            $display("dataset_row_stats_labeler verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/drs_pkg.sv
hw/rtl/drs_ram.sv
hw/rtl/drs_queue.sv
hw/rtl/drs_front.sv
hw/rtl/drs_back.sv
hw/rtl/dataset_row_stats_labeler.sv
test/dataset_row_stats_labeler_test.sv
